@@ hdl/tso_store_buffer_forwarding_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the TSO store buffer block
// ---------------------------------------------------------------------------
`ifndef TSO_STORE_BUFFER_FORWARDING_ASSERT_SVH
`define TSO_STORE_BUFFER_FORWARDING_ASSERT_SVH
// implication checked on every clock edge outside reset
`define TSB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// implication checked in the cycle after the antecedent
`define TSB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

@@ hdl/tsb_pkg.sv @@
// ---------------------------------------------------------------------------
// tsb_pkg
// Shared types and constants of the TSO store buffer block.
// ---------------------------------------------------------------------------
package tsb_pkg;
	localparam int THREADS_DEF      = 4;
	localparam int BUFFER_DEPTH_DEF = 8;
	localparam int LOCATIONS_DEF    = 256;

	localparam logic [2:0] FUNC_READ    = 3'd0;
	localparam logic [2:0] FUNC_WRITE   = 3'd1;
	localparam logic [2:0] FUNC_FENCE   = 3'd2;
	localparam logic [2:0] FUNC_PROP    = 3'd3;
	localparam logic [2:0] FUNC_DRAIN   = 3'd4;
	localparam logic [2:0] FUNC_DRAINALL = 3'd5;

	// controller to datapath
	typedef struct packed {
		logic capture;     // latch input request
		logic clr_step;    // clear memory at clear index, advance
		logic search;      // run forwarding search, register result
		logic mem_rd;      // issue memory read at request address
		logic commit;      // commit oldest entry of selected thread
		logic append;      // append request entry
		logic sel_all;     // commit thread comes from the sweep counter
		logic next_thr;    // advance sweep counter
		logic rst_thr;     // zero sweep counter
		logic load_out;    // load result register
	} tsb_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_done;
		logic thr_empty;   // selected commit thread has no entries
		logic thr_full;    // request thread is full
		logic thr_last;    // sweep counter at last thread
	} tsb_sts_t;
endpackage

@@ hdl/tsb_datapath.sv @@
// ---------------------------------------------------------------------------
// tsb_datapath
// Shared memory, per-thread store FIFOs, forwarding search and result.
// ---------------------------------------------------------------------------
`include "tso_store_buffer_forwarding_assert.svh"
module tsb_datapath #(
	parameter int THREADS      = tsb_pkg::THREADS_DEF,
	parameter int BUFFER_DEPTH = tsb_pkg::BUFFER_DEPTH_DEF,
	parameter int LOCATIONS    = tsb_pkg::LOCATIONS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tsb_pkg::tsb_cmd_t cmd,
	output tsb_pkg::tsb_sts_t sts,
	input  logic [2:0]        in_func,
	input  logic [1:0]        in_thread,
	input  logic [7:0]        in_address,
	input  logic [31:0]       in_data,
	input  logic              in_seq_cst,
	output logic [2:0]        func_q,
	output logic              seq_cst_q,
	output logic [31:0]       read_value,
	output logic              buffer_pending
);
	localparam int TW = (THREADS > 1) ? $clog2(THREADS) : 1;
	localparam int DW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam int CW = $clog2(BUFFER_DEPTH + 1);
	localparam int AW = (LOCATIONS > 1) ? $clog2(LOCATIONS) : 1;
	localparam int EW = AW + 32;

	logic [TW-1:0] thr_q, sweep_q, cthr;
	logic [AW-1:0] addr_q, clr_q;
	logic [31:0]   data_q;
	logic [DW-1:0] head_q [THREADS];
	logic [CW-1:0] cnt_q  [THREADS];
	logic [EW-1:0] ent_q  [THREADS][BUFFER_DEPTH];
	logic [31:0]   mem [LOCATIONS];
	logic [31:0]   mem_rd_q, fwd_q;
	logic          hit_q, clr_done_q;

	// wrap thread and address to their ranges
	logic [TW-1:0] in_thr_w;
	logic [AW-1:0] in_addr_w;
	always_comb begin
		in_thr_w  = TW'(32'(in_thread) % THREADS);
		in_addr_w = AW'(32'(in_address) % LOCATIONS);
	end

	assign cthr = cmd.sel_all ? sweep_q : thr_q;

	// capture request
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			thr_q     <= in_thr_w;
			addr_q    <= in_addr_w;
			data_q    <= in_data;
			func_q    <= in_func;
			seq_cst_q <= in_seq_cst;
		end
	end

	// oldest entry of commit thread
	logic [EW-1:0] old_e;
	assign old_e = ent_q[cthr][head_q[cthr]];

	// forwarding search: newest match across the thread's buffer
	logic          fhit;
	logic [31:0]   fval;
	logic [DW-1:0] pos;
	always_comb begin
		fhit = 1'b0;
		fval = '0;
		pos  = '0;
		for (int k = 0; k < BUFFER_DEPTH; k++) begin
			pos = DW'((32'(head_q[thr_q]) + k) % BUFFER_DEPTH);
			if (CW'(k) < cnt_q[thr_q] && ent_q[thr_q][pos][AW+31:32] == addr_q) begin
				fhit = 1'b1;
				fval = ent_q[thr_q][pos][31:0];
			end
		end
	end

	// sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else if (cmd.rst_thr) begin
			sweep_q <= '0;
		end else if (cmd.next_thr) begin
			sweep_q <= sweep_q + 1'b1;
		end
	end

	// clear index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			clr_done_q <= 1'b0;
		end else if (cmd.clr_step) begin
			clr_q <= clr_q + 1'b1;
			if (32'(clr_q) == LOCATIONS - 1) clr_done_q <= 1'b1;
		end
	end

	// shared memory: one write port, one read port
	always_ff @(posedge clk) begin
		if (cmd.clr_step) begin
			mem[clr_q] <= '0;
		end else if (cmd.commit) begin
			mem[old_e[AW+31:32]] <= old_e[31:0];
		end
		if (cmd.mem_rd) mem_rd_q <= mem[addr_q];
	end

	// forwarding result
	always_ff @(posedge clk) begin
		if (cmd.search) begin
			hit_q <= fhit;
			fwd_q <= fval;
		end
	end

	// FIFO control: commit advances head, append writes tail
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < THREADS; t++) begin
				head_q[t] <= '0;
				cnt_q[t]  <= '0;
			end
		end else if (cmd.commit) begin
			head_q[cthr] <= DW'((32'(head_q[cthr]) + 1) % BUFFER_DEPTH);
			cnt_q[cthr]  <= cnt_q[cthr] - 1'b1;
		end else if (cmd.append) begin
			cnt_q[thr_q] <= cnt_q[thr_q] + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.append) begin
			ent_q[thr_q][DW'((32'(head_q[thr_q]) + 32'(cnt_q[thr_q])) % BUFFER_DEPTH)]
				<= {addr_q, data_q};
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			read_value     <= (func_q == tsb_pkg::FUNC_READ) ?
				(hit_q ? fwd_q : mem_rd_q) : 32'd0;
			buffer_pending <= (cnt_q[thr_q] != '0);
		end
	end

	always_comb begin
		sts.clr_done  = clr_done_q;
		sts.thr_empty = (cnt_q[cthr] == '0);
		sts.thr_full  = (32'(cnt_q[thr_q]) >= BUFFER_DEPTH);
		sts.thr_last  = (32'(sweep_q) == THREADS - 1);
	end

	`TSB_ASSERT_IMP(a_commit_nonempty, clk, arst_n, cmd.commit, cnt_q[cthr] != '0, "commit on empty buffer")
	`TSB_ASSERT_IMP(a_append_room, clk, arst_n, cmd.append, 32'(cnt_q[thr_q]) < BUFFER_DEPTH, "append to full buffer")
	`TSB_ASSERT_IMP(a_no_commit_clear, clk, arst_n, cmd.clr_step, !cmd.commit && !cmd.append, "buffer activity during clear")
endmodule

@@ hdl/tsb_ctrl.sv @@
// ---------------------------------------------------------------------------
// tsb_ctrl
// Sequencer for request handling, drains and memory clearing.
// ---------------------------------------------------------------------------
`include "tso_store_buffer_forwarding_assert.svh"
module tsb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	input  logic [2:0]        func_q,
	input  logic              seq_cst_q,
	input  tsb_pkg::tsb_sts_t sts,
	output tsb_pkg::tsb_cmd_t cmd
);
	typedef enum logic [7:0] {
		ST_CLEAR = 8'b00000001,
		ST_IDLE  = 8'b00000010,
		ST_DEC   = 8'b00000100,
		ST_READ  = 8'b00001000,
		ST_WRITE = 8'b00010000,
		ST_DRAIN = 8'b00100000,
		ST_ALL   = 8'b01000000,
		ST_OUT   = 8'b10000000
	} state_t;

	state_t state_q, state_d;
	logic   out_v_q;

	// output holding register frees the core for the next request
	assign m_tvalid = out_v_q;
	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = !sts.clr_done;
				if (sts.clr_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				cmd.capture = s_tvalid;
				if (s_tvalid) state_d = ST_DEC;
			end
			ST_DEC: begin
				cmd.search  = 1'b1;
				cmd.mem_rd  = 1'b1;
				cmd.rst_thr = 1'b1;
				unique case (func_q)
					tsb_pkg::FUNC_READ:  state_d = ST_READ;
					tsb_pkg::FUNC_WRITE: state_d = ST_WRITE;
					tsb_pkg::FUNC_FENCE: state_d = seq_cst_q ? ST_DRAIN : ST_OUT;
					tsb_pkg::FUNC_PROP: begin
						cmd.commit = !sts.thr_empty;
						state_d    = ST_OUT;
					end
					tsb_pkg::FUNC_DRAIN:    state_d = ST_DRAIN;
					tsb_pkg::FUNC_DRAINALL: state_d = ST_ALL;
					default:                state_d = ST_OUT;
				endcase
			end
			ST_READ: begin
				state_d = ST_OUT;
			end
			ST_WRITE: begin
				// full buffer: commit oldest first, then append
				if (sts.thr_full) begin
					cmd.commit = 1'b1;
				end else begin
					cmd.append = 1'b1;
					state_d    = seq_cst_q ? ST_DRAIN : ST_OUT;
				end
			end
			ST_DRAIN: begin
				if (sts.thr_empty) state_d = ST_OUT;
				else cmd.commit = 1'b1;
			end
			ST_ALL: begin
				cmd.sel_all = 1'b1;
				if (!sts.thr_empty) begin
					cmd.commit = 1'b1;
				end else if (sts.thr_last) begin
					state_d = ST_OUT;
				end else begin
					cmd.next_thr = 1'b1;
				end
			end
			ST_OUT: begin
				if (!out_v_q || m_tready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) out_v_q <= 1'b1;
			else if (m_tready) out_v_q <= 1'b0;
		end
	end

	`TSB_ASSERT_IMP(a_onehot, clk, arst_n, 1'b1, $onehot(state_q), "state not one-hot")
	`TSB_ASSERT_NEXT(a_load_valid, clk, arst_n, cmd.load_out, m_tvalid, "result not presented")
	`TSB_ASSERT_IMP(a_ready_idle, clk, arst_n, s_tready, !cmd.commit && !cmd.append, "accepting while busy")
endmodule

@@ hdl/tso_store_buffer_forwarding.sv @@
// ---------------------------------------------------------------------------
// tso_store_buffer_forwarding
// TSO shared memory with per-thread store buffers and load forwarding.
// ---------------------------------------------------------------------------
// After reset the block clears its LOCATIONS-word memory, one word per cycle,
// and accepts no request until the clear is done. One request is handled at a
// time. Propagate, fence without seq_cst and unused codes pass from decode to
// the output state; a read passes through decode, read and output; a write
// through decode, write and output, committing the oldest entry before its
// append when its buffer is full. Memory has one write port, so a drain
// commits one entry per cycle: fence with seq_cst and drain-thread drain the
// request thread, a write with seq_cst drains it after the append, and
// drain-all sweeps every thread in turn. The next request is taken in the
// cycle after the result is loaded. The result register lets the next request
// enter while a result waits downstream.
module tso_store_buffer_forwarding #(
	parameter int THREADS      = tsb_pkg::THREADS_DEF,
	parameter int BUFFER_DEPTH = tsb_pkg::BUFFER_DEPTH_DEF,
	parameter int LOCATIONS    = tsb_pkg::LOCATIONS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// tdata: thread[1:0], address[9:2], data[41:10], seq_cst[42]
	input  logic [47:0] s_tdata,
	// tuser: func[2:0]
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// tdata: read_value[31:0], buffer_pending[32]
	output logic [39:0] m_tdata
);
	tsb_pkg::tsb_cmd_t cmd;
	tsb_pkg::tsb_sts_t sts;
	logic [2:0]  func_q;
	logic        seq_cst_q;
	logic [31:0] read_value;
	logic        buffer_pending;

	tsb_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready),
		.m_tvalid(m_tvalid), .m_tready(m_tready),
		.func_q(func_q), .seq_cst_q(seq_cst_q),
		.sts(sts), .cmd(cmd)
	);

	tsb_datapath #(
		.THREADS(THREADS), .BUFFER_DEPTH(BUFFER_DEPTH), .LOCATIONS(LOCATIONS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.in_func(s_tuser), .in_thread(s_tdata[1:0]),
		.in_address(s_tdata[9:2]), .in_data(s_tdata[41:10]),
		.in_seq_cst(s_tdata[42]),
		.func_q(func_q), .seq_cst_q(seq_cst_q),
		.read_value(read_value), .buffer_pending(buffer_pending)
	);

	assign m_tdata = {7'd0, buffer_pending, read_value};
endmodule

@@ bench/tb_tso_store_buffer_forwarding.sv @@
// ---------------------------------------------------------------------------
// tb_tso_store_buffer_forwarding
// Stream-level check of the TSO store buffer with load forwarding. Requests
// are driven with random gaps, results are taken with random stalls and each
// one is compared with a TSO memory model kept inside the bench.
// ---------------------------------------------------------------------------
class tso_scoreboard;
	logic [31:0] mem_word [256];
	logic [7:0]  sb_addr [4][8];
	logic [31:0] sb_data [4][8];
	int          sb_head [4];
	int          sb_count [4];
	logic [32:0] exp_ring [64];
	int          exp_wr;
	int          exp_rd;
	int          exp_level;
	int          failures;

	function new();
		foreach (mem_word[i]) mem_word[i] = '0;
		foreach (sb_head[i]) begin
			sb_head[i] = 0;
			sb_count[i] = 0;
		end
		exp_wr = 0;
		exp_rd = 0;
		exp_level = 0;
		failures = 0;
	endfunction

	// results still expected from the block
	function int outstanding();
		return exp_level;
	endfunction

	// queue one expected result
	function void add_expected(logic [32:0] r);
		exp_ring[exp_wr] = r;
		exp_wr = (exp_wr + 1) % 64;
		exp_level++;
	endfunction

	// take the oldest expected result
	function logic [32:0] take_expected();
		logic [32:0] r;
		r = exp_ring[exp_rd];
		exp_rd = (exp_rd + 1) % 64;
		exp_level--;
		return r;
	endfunction

	// commit the oldest entry of one thread to memory
	function void commit_oldest(int t);
		if (sb_count[t] == 0) return;
		mem_word[sb_addr[t][sb_head[t]]] = sb_data[t][sb_head[t]];
		sb_head[t] = (sb_head[t] + 1) % 8;
		sb_count[t]--;
	endfunction

	function void drain_thread(int t);
		while (sb_count[t] != 0) commit_oldest(t);
	endfunction

	// note an accepted request and queue its result
	function void note_request(logic [2:0] func, logic [1:0] thr, logic [7:0] addr,
			logic [31:0] data, logic sc);
		logic [31:0] rv;
		int t;
		int pos;
		rv = '0;
		t = thr;
		case (func)
			tsb_pkg::FUNC_READ: begin
				rv = mem_word[addr];
				for (int k = 0; k < sb_count[t]; k++) begin
					pos = (sb_head[t] + k) % 8;
					if (sb_addr[t][pos] == addr) rv = sb_data[t][pos];
				end
			end
			tsb_pkg::FUNC_WRITE: begin
				if (sb_count[t] >= 8) commit_oldest(t);
				pos = (sb_head[t] + sb_count[t]) % 8;
				sb_addr[t][pos] = addr;
				sb_data[t][pos] = data;
				sb_count[t]++;
				if (sc) drain_thread(t);
			end
			tsb_pkg::FUNC_FENCE: if (sc) drain_thread(t);
			tsb_pkg::FUNC_PROP: commit_oldest(t);
			tsb_pkg::FUNC_DRAIN: drain_thread(t);
			tsb_pkg::FUNC_DRAINALL: for (int i = 0; i < 4; i++) drain_thread(i);
			default: ;
		endcase
		add_expected({sb_count[t] != 0, rv});
	endfunction

	// compare one result with the oldest expectation
	function void check_result(logic [39:0] tdata);
		logic [32:0] exp_r;
		if (exp_level == 0) begin
			$error("unexpected result %h", tdata);
			failures++;
			return;
		end
		exp_r = take_expected();
		if (tdata[31:0] !== exp_r[31:0]) begin
			$error("read_value expected %h actual %h", exp_r[31:0], tdata[31:0]);
			failures++;
		end
		if (tdata[32] !== exp_r[32]) begin
			$error("buffer_pending expected %b actual %b", exp_r[32], tdata[32]);
			failures++;
		end
	endfunction
endclass

module tb_tso_store_buffer_forwarding;
	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;
	logic [2:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;

	tso_scoreboard tso_model;
	bit            calm_phase;
	bit            sending_done;
	int            cycle_count;
	int            hot_addr [4];

	tso_store_buffer_forwarding DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		arst_n = 1'b0;
		calm_phase = 1'b0;
		sending_done = 1'b0;
		tso_model = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	// send one request, optionally after an idle burst
	task automatic send_request(logic [2:0] func, logic [1:0] thr, logic [7:0] addr,
			logic [31:0] data, logic sc);
		if (!calm_phase && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {5'b0, sc, data, addr, thr};
		s_tuser <= func;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		tso_model.note_request(func, thr, addr, data, sc);
	endtask

	task automatic wait_results_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (tso_model.outstanding() != 0) @(posedge clk);
	endtask

	// random request, weighted toward writes and reads on a few hot addresses
	task automatic send_random();
		logic [2:0]  func;
		logic [1:0]  thr;
		logic [7:0]  addr;
		int          pick;
		pick = $urandom_range(0, 99);
		thr = 2'($urandom_range(0, 3));
		if (pick < 40) func = tsb_pkg::FUNC_WRITE;
		else if (pick < 75) func = tsb_pkg::FUNC_READ;
		else if (pick < 82) func = tsb_pkg::FUNC_PROP;
		else if (pick < 88) func = tsb_pkg::FUNC_FENCE;
		else if (pick < 93) func = tsb_pkg::FUNC_DRAIN;
		else if (pick < 96) func = tsb_pkg::FUNC_DRAINALL;
		else func = 3'($urandom_range(6, 7));
		addr = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
			: 8'(hot_addr[$urandom_range(0, 3)]);
		send_request(func, thr, addr, $urandom, $urandom_range(0, 5) == 0);
	endtask

	// stimulus
	initial begin
		hot_addr = '{8'h00, 8'h3c, 8'hc3, 8'hff};
		@(posedge arst_n);
		@(posedge clk);
		// extremes, every operation and the special cases
		send_request(tsb_pkg::FUNC_READ, 2'd0, 8'h00, 32'h0, 1'b0);
		send_request(tsb_pkg::FUNC_WRITE, 2'd0, 8'hff, 32'h7fffffff, 1'b0);
		send_request(tsb_pkg::FUNC_READ, 2'd0, 8'hff, 32'h0, 1'b1);
		send_request(tsb_pkg::FUNC_READ, 2'd1, 8'hff, 32'h0, 1'b0);
		send_request(tsb_pkg::FUNC_WRITE, 2'd0, 8'hff, 32'h80000000, 1'b0);
		send_request(tsb_pkg::FUNC_READ, 2'd0, 8'hff, 32'h0, 1'b0);
		send_request(tsb_pkg::FUNC_FENCE, 2'd0, 8'h00, 32'h0, 1'b0);
		send_request(tsb_pkg::FUNC_PROP, 2'd0, 8'h00, 32'h0, 1'b0);
		send_request(tsb_pkg::FUNC_READ, 2'd1, 8'hff, 32'h0, 1'b0);
		send_request(tsb_pkg::FUNC_FENCE, 2'd0, 8'h00, 32'h0, 1'b1);
		send_request(tsb_pkg::FUNC_PROP, 2'd3, 8'h00, 32'h0, 1'b0);
		for (int i = 0; i < 10; i++)
			send_request(tsb_pkg::FUNC_WRITE, 2'd3, i[7:0], 32'hffffffff - i, 1'b0);
		send_request(tsb_pkg::FUNC_READ, 2'd2, 8'h01, 32'h0, 1'b0);
		send_request(tsb_pkg::FUNC_DRAIN, 2'd3, 8'h00, 32'h0, 1'b0);
		send_request(tsb_pkg::FUNC_WRITE, 2'd2, 8'h55, 32'h12345678, 1'b1);
		send_request(3'd6, 2'd1, 8'haa, 32'h0, 1'b1);
		send_request(3'd7, 2'd2, 8'h00, 32'h0, 1'b0);
		send_request(tsb_pkg::FUNC_DRAINALL, 2'd1, 8'h00, 32'h0, 1'b0);
		wait_results_drained();
		// random part with a full pause in the middle
		for (int n = 0; n < 830; n++) begin
			if (n == 400) wait_results_drained();
			if (n == 700) calm_phase = 1'b1;
			send_random();
		end
		s_tvalid <= 1'b0;
		sending_done = 1'b1;
	end

	// result side with random stall bursts
	initial begin
		@(posedge arst_n);
		forever begin
			if (!calm_phase && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			if (m_tvalid && m_tready) tso_model.check_result(m_tdata);
		end
	end

	// end of run and timeout
	initial begin
		cycle_count = 0;
		while (!(sending_done && tso_model.outstanding() == 0)
				&& cycle_count < 200000) begin
			@(posedge clk);
			cycle_count++;
		end
		if (cycle_count >= 200000) begin
			$display("Test completed with failures");
		end else begin
			repeat (100) @(posedge clk);
			if (tso_model.failures == 0 && tso_model.outstanding() == 0) begin
				$display("Test completed successfully");
			end else begin
				$display("Test completed with failures");
			end
		end
		$finish;
	end
endmodule

@@ filelist.f @@
+incdir+hdl
hdl/tsb_pkg.sv
hdl/tsb_datapath.sv
hdl/tsb_ctrl.sv
hdl/tso_store_buffer_forwarding.sv
bench/tb_tso_store_buffer_forwarding.sv
